// ===== rtl/core/slpt_pkg.sv =====
// Shared types and helpers for the slot pool lifecycle tracker.
// Holds request function codes, lifecycle state codes and the legal-move check.
// No dependencies.
`default_nettype none

package slpt_pkg;

   typedef enum logic [1:0] {
      FUNC_RESERVE    = 2'd0,
      FUNC_TRANSITION = 2'd1,
      FUNC_RELEASE    = 2'd2,
      FUNC_QUERY      = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      LC_FREE       = 3'd0,
      LC_RESERVED   = 3'd1,
      LC_QHIGH      = 3'd2,
      LC_QNORMAL    = 3'd3,
      LC_DISPATCHED = 3'd4,
      LC_PROCESSING = 3'd5,
      LC_RESPONDED  = 3'd6
   } life_type;

   function automatic logic legal_move(input logic [2:0] cur, input logic [2:0] nxt);
      logic res;
      unique case (cur)
         LC_RESERVED: begin
            res = (nxt == LC_QHIGH) || (nxt == LC_QNORMAL);
         end
         LC_QHIGH, LC_QNORMAL: begin
            res = (nxt == LC_DISPATCHED);
         end
         LC_DISPATCHED: begin
            res = (nxt == LC_PROCESSING);
         end
         LC_PROCESSING: begin
            res = (nxt == LC_RESPONDED);
         end
         default: begin
            res = 1'b0;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slot_pool_lifecycle_tracker.sv =====
// Slot pool lifecycle tracker: FIFO free list allocator with per-slot lifecycle state.
// Depends on slpt_pkg and slpt_ram.
//
// Usage:
//   Request channel (req_*): func selects reserve, transition, release or state
//   query; slot and target address the slot and the requested state.
//   Response channel (rsp_*): one response per request, in order, carrying ok,
//   granted_slot and slot_state.
//   A request goes to the request register, then its reply to the response
//   register. One request per cycle unless stalled; the request register reads
//   the state RAM and the free-list RAM, the next stage checks and writes both,
//   with forwarding when the following request hits the slot just written.
//   Reset: all slots free, free list holds 0..SLOTS-1 in order, both channels
//   empty. Per-entry valid flops stand in for the RAM contents after reset, so
//   no clearing pass is needed and a request can be taken right after reset.
//   Stall: while rsp_ready is low with a response pending, req_ready drops and
//   the request in flight holds with its read data.
`default_nettype none

module slot_pool_lifecycle_tracker
   import slpt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_slot,
   input  wire logic [2:0] req_target,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_ok,
   output logic [7:0]      rsp_granted_slot,
   output logic [2:0]      rsp_slot_state
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

   logic             adv;
   logic             load;
   logic             commit;

   logic             s1_valid_ff;
   func_type         s1_func_ff;
   logic [7:0]       s1_idx_ff;
   logic [2:0]       s1_next_ff;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [SLOTS-1:0] life_vld_ff;
   logic [SLOTS-1:0] fq_vld_ff;

   logic             life_fwd_ff;
   logic [2:0]       life_fwd_data_ff;
   logic             fq_fwd_ff;
   logic [IDX_W-1:0] fq_fwd_data_ff;

   logic [2:0]       life_rd;
   logic [IDX_W-1:0] fq_rd;

   logic             life_we;
   logic [IDX_W-1:0] life_waddr;
   logic [2:0]       life_wdata;
   logic             fq_we;
   logic [IDX_W-1:0] fq_waddr;
   logic [IDX_W-1:0] fq_wdata;

   logic             in_range;
   logic [IDX_W-1:0] slot_addr;
   logic [2:0]       cur_state;
   logic [IDX_W-1:0] head_slot;

   logic             ok_in;
   logic [7:0]       granted_in;
   logic [2:0]       state_in;

   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic [7:0]       rsp_granted_ff;
   logic [2:0]       rsp_state_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign load      = req_valid && adv;
   assign commit    = s1_valid_ff && adv;

   assign in_range  = {1'b0, s1_idx_ff} < 9'(SLOTS);
   assign slot_addr = s1_idx_ff[IDX_W-1:0];
   assign cur_state = life_fwd_ff ? life_fwd_data_ff :
                      (life_vld_ff[slot_addr] ? life_rd : LC_FREE);
   assign head_slot = fq_fwd_ff ? fq_fwd_data_ff :
                      (fq_vld_ff[head_ff] ? fq_rd : head_ff);

   always_comb begin
      ok_in      = 1'b0;
      granted_in = 8'd0;
      state_in   = LC_FREE;
      life_we    = 1'b0;
      life_waddr = slot_addr;
      life_wdata = LC_FREE;
      fq_we      = 1'b0;
      fq_waddr   = tail_ff;
      fq_wdata   = slot_addr;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      unique case (s1_func_ff)
         FUNC_RESERVE: begin
            if (count_ff != '0) begin
               ok_in      = 1'b1;
               granted_in = 8'(head_slot);
               life_we    = 1'b1;
               life_waddr = head_slot;
               life_wdata = LC_RESERVED;
               head_in    = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         FUNC_TRANSITION: begin
            if (in_range && legal_move(cur_state, s1_next_ff)) begin
               ok_in      = 1'b1;
               life_we    = 1'b1;
               life_wdata = s1_next_ff;
            end
         end
         FUNC_RELEASE: begin
            if (in_range && cur_state != LC_FREE) begin
               ok_in   = 1'b1;
               life_we = 1'b1;
               if (count_ff < FULL_CNT) begin
                  fq_we    = 1'b1;
                  tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         FUNC_QUERY: begin
            state_in = in_range ? cur_state : LC_FREE;
         end
      endcase
      if (!commit) begin
         life_we  = 1'b0;
         fq_we    = 1'b0;
         head_in  = head_ff;
         tail_in  = tail_ff;
         count_in = count_ff;
      end
   end

   slpt_ram #(
      .WIDTH(3),
      .DEPTH(SLOTS)
   ) u_life_ram (
      .clock  (clock),
      .wr_en  (life_we),
      .wr_addr(life_waddr),
      .wr_data(life_wdata),
      .rd_en  (load),
      .rd_addr(req_slot[IDX_W-1:0]),
      .rd_data(life_rd)
   );

   slpt_ram #(
      .WIDTH(IDX_W),
      .DEPTH(SLOTS)
   ) u_fq_ram (
      .clock  (clock),
      .wr_en  (fq_we),
      .wr_addr(fq_waddr),
      .wr_data(fq_wdata),
      .rd_en  (load),
      .rd_addr(head_in),
      .rd_data(fq_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= FULL_CNT;
         life_vld_ff  <= '0;
         fq_vld_ff    <= '0;
         life_fwd_ff  <= 1'b0;
         fq_fwd_ff    <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (life_we) begin
            life_vld_ff[life_waddr] <= 1'b1;
         end
         if (fq_we) begin
            fq_vld_ff[fq_waddr] <= 1'b1;
         end
         if (adv) begin
            s1_valid_ff  <= req_valid;
            rsp_valid_ff <= s1_valid_ff;
         end
         if (load) begin
            life_fwd_ff <= life_we && (life_waddr == req_slot[IDX_W-1:0]);
            fq_fwd_ff   <= fq_we && (fq_waddr == head_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_func_ff       <= func_type'(req_func);
         s1_idx_ff        <= req_slot;
         s1_next_ff       <= req_target;
         life_fwd_data_ff <= life_wdata;
         fq_fwd_data_ff   <= fq_wdata;
      end
      if (commit) begin
         rsp_ok_ff      <= ok_in;
         rsp_granted_ff <= granted_in;
         rsp_state_ff   <= state_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_slot_state   = rsp_state_ff;

endmodule

`default_nettype wire

// ===== rtl/core/slpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`default_nettype none

module slpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/slpt_checker.sv =====
// Port-level checker for the slot pool lifecycle tracker, bound to the top level.
// Depends on slpt_pkg and slot_pool_lifecycle_tracker.
`default_nettype none

module slpt_checker
   import slpt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_ok,
   input wire logic [7:0] rsp_granted_slot,
   input wire logic [2:0] rsp_slot_state
);

   a_grant_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_slot != 8'd0 |-> rsp_ok)
      else $error("granted slot without ok");

   a_query_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_state != LC_FREE |-> !rsp_ok && rsp_granted_slot == 8'd0)
      else $error("query response carries ok or grant");

   a_grant_in_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_granted_slot} < 9'(SLOTS))
      else $error("granted slot outside pool");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_granted_slot) && $stable(rsp_slot_state))
      else $error("stalled response changed");

endmodule

bind slot_pool_lifecycle_tracker slpt_checker #(.SLOTS(SLOTS)) u_slpt_checker (.*);

`default_nettype wire

// ===== bench/slpt_checker.sv =====
// Response checker for the slot pool lifecycle tracker bench.
// Watches both channels, predicts each response in order and counts mismatches.
// Depends on slpt_pkg for the request and lifecycle codes.
module slpt_scoreboard
   import slpt_pkg::*;
#(
   parameter int POOL_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_slot,
   input  logic [2:0] req_target,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_ok,
   input  logic [7:0] rsp_granted_slot,
   input  logic [2:0] rsp_slot_state,
   output int         mismatch_count,
   output int         outstanding,
   output int         responses_seen,
   output int         empty_denials,
   output int         completed_lifecycles
);

   typedef struct packed {
      logic       ok;
      logic [7:0] granted;
      logic [2:0] state;
   } slot_reply_type;

   life_type       lc_state [POOL_SIZE];
   logic [7:0]     free_ring [POOL_SIZE];
   int             ring_head;
   int             ring_tail;
   int             ring_fill;
   slot_reply_type replies_due [$];

   function automatic logic may_advance(input life_type from, input logic [2:0] to);
      case (from)
         LC_RESERVED:            return to inside {LC_QHIGH, LC_QNORMAL};
         LC_QHIGH, LC_QNORMAL:   return to == LC_DISPATCHED;
         LC_DISPATCHED:          return to == LC_PROCESSING;
         LC_PROCESSING:          return to == LC_RESPONDED;
         default:                return 1'b0;
      endcase
   endfunction

   task automatic clear_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         lc_state[i]  = LC_FREE;
         free_ring[i] = 8'(i);
      end
      ring_head = 0;
      ring_tail = 0;
      ring_fill = POOL_SIZE;
   endtask

   task automatic predict_reply(input logic [1:0] fn, input logic [7:0] idx,
                                input logic [2:0] nxt, output slot_reply_type r);
      logic       hit;
      logic [7:0] s;
      hit = idx < POOL_SIZE;
      r   = '0;
      case (func_type'(fn))
         FUNC_RESERVE: begin
            if (ring_fill > 0) begin
               s = free_ring[ring_head];
               ring_head = (ring_head + 1) % POOL_SIZE;
               ring_fill--;
               lc_state[s] = LC_RESERVED;
               r.ok      = 1'b1;
               r.granted = s;
            end else begin
               empty_denials++;
            end
         end
         FUNC_TRANSITION: begin
            if (hit && may_advance(lc_state[idx], nxt)) begin
               lc_state[idx] = life_type'(nxt);
               r.ok = 1'b1;
               if (nxt == LC_RESPONDED) completed_lifecycles++;
            end
         end
         FUNC_RELEASE: begin
            if (hit && lc_state[idx] != LC_FREE) begin
               lc_state[idx] = LC_FREE;
               if (ring_fill < POOL_SIZE) begin
                  free_ring[ring_tail] = idx;
                  ring_tail = (ring_tail + 1) % POOL_SIZE;
                  ring_fill++;
               end
               r.ok = 1'b1;
            end
         end
         default: begin
            r.state = hit ? lc_state[idx] : LC_FREE;
         end
      endcase
   endtask

   always @(posedge clock) begin
      slot_reply_type want;
      slot_reply_type got;
      if (reset) begin
         clear_pool();
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            got = '{rsp_ok, rsp_granted_slot, rsp_slot_state};
            if (replies_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch %0d: unexpected response ok=%0d slot=%0d state=%0d",
                           mismatch_count, got.ok, got.granted, got.state);
            end else begin
               want = replies_due.pop_front();
               if (got.ok !== want.ok || got.granted !== want.granted
                   || got.state !== want.state) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch %0d (ok/slot/state): exp %0d/%0d/%0d got %0d/%0d/%0d",
                              mismatch_count, want.ok, want.granted, want.state,
                              got.ok, got.granted, got.state);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_reply(req_func, req_slot, req_target, want);
            replies_due.push_back(want);
         end
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== bench/tb_slot_pool_lifecycle_tracker.sv =====
// Top of the slot pool lifecycle tracker bench: clock, reset, request stimulus
// and verdict. Depends on slpt_pkg, the tracker RTL and slpt_scoreboard.
module tb_slot_pool_lifecycle_tracker;
   import slpt_pkg::*;

   localparam int         POOL_SIZE    = 16;
   localparam int         RANDOM_ITEMS = 1050;
   localparam logic [2:0] CODE_UNUSED  = 3'd7;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic [1:0] req_func       = FUNC_QUERY;
   logic [7:0] req_slot       = 8'd0;
   logic [2:0] req_target     = LC_FREE;
   logic       rsp_ready      = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_ok;
   logic [7:0] rsp_granted_slot;
   logic [2:0] rsp_slot_state;

   int mismatch_count;
   int outstanding;
   int responses_seen;
   int empty_denials;
   int completed_lifecycles;

   int requests_sent = 0;
   int directed_total;
   int pauses = 0;
   int stall_left = 0;
   bit steady = 1'b0;

   always #5 clock = ~clock;

   slot_pool_lifecycle_tracker #(.SLOTS(POOL_SIZE)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_target       (req_target),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_slot_state   (rsp_slot_state)
   );

   slpt_scoreboard #(.POOL_SIZE(POOL_SIZE)) u_scoreboard (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_slot             (req_slot),
      .req_target           (req_target),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ok               (rsp_ok),
      .rsp_granted_slot     (rsp_granted_slot),
      .rsp_slot_state       (rsp_slot_state),
      .mismatch_count       (mismatch_count),
      .outstanding          (outstanding),
      .responses_seen       (responses_seen),
      .empty_denials        (empty_denials),
      .completed_lifecycles (completed_lifecycles)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] any_index();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] any_state();
      return 3'($urandom_range(0, 7));
   endfunction

   task automatic issue(input func_type f, input logic [7:0] idx, input logic [2:0] nxt);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= f;
      req_slot   <= idx;
      req_target <= nxt;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic run_lifecycle(input logic [7:0] slot);
      logic [2:0] path [4];
      path[0] = $urandom_range(0, 1) ? LC_QHIGH : LC_QNORMAL;
      path[1] = LC_DISPATCHED;
      path[2] = LC_PROCESSING;
      path[3] = LC_RESPONDED;
      if ($urandom_range(0, 1)) issue(FUNC_RESERVE, any_index(), any_state());
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 9) == 0) issue(FUNC_TRANSITION, slot, any_state());
         if ($urandom_range(0, 5) == 0) issue(FUNC_QUERY, slot, any_state());
         issue(FUNC_TRANSITION, slot, path[k]);
      end
      if ($urandom_range(0, 9) < 7) issue(FUNC_RELEASE, slot, any_state());
   endtask

   task automatic random_request();
      logic [7:0] idx;
      idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, POOL_SIZE - 1)) : any_index();
      issue(func_type'($urandom_range(0, 3)), idx, any_state());
   endtask

   // receiver side: random back-pressure, none during steady stretches
   initial begin
      forever begin
         @(posedge clock);
         if (steady) begin
            rsp_ready  <= 1'b1;
            stall_left = 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end else if (rsp_ready) begin
            rsp_ready  <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = $urandom_range(0, 12);
         end
      end
   end

   initial begin
      int pick;
      int start;
      int burst;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      issue(FUNC_QUERY, 8'd255, LC_FREE);
      issue(FUNC_QUERY, 8'd16, LC_FREE);
      issue(FUNC_QUERY, 8'd0, CODE_UNUSED);
      issue(FUNC_RELEASE, 8'd0, LC_FREE);
      issue(FUNC_TRANSITION, 8'd0, LC_RESERVED);
      issue(FUNC_RESERVE, 8'd255, CODE_UNUSED);
      issue(FUNC_TRANSITION, 8'd0, LC_FREE);
      issue(FUNC_TRANSITION, 8'd0, CODE_UNUSED);
      issue(FUNC_TRANSITION, 8'd0, LC_DISPATCHED);
      issue(FUNC_TRANSITION, 8'd0, LC_QHIGH);
      issue(FUNC_TRANSITION, 8'd0, LC_DISPATCHED);
      issue(FUNC_TRANSITION, 8'd0, LC_PROCESSING);
      issue(FUNC_TRANSITION, 8'd0, LC_RESPONDED);
      issue(FUNC_TRANSITION, 8'd0, LC_RESPONDED);
      issue(FUNC_QUERY, 8'd0, LC_FREE);
      issue(FUNC_RELEASE, 8'd0, LC_FREE);
      issue(FUNC_RELEASE, 8'd0, LC_FREE);
      issue(FUNC_RESERVE, 8'd0, LC_FREE);
      issue(FUNC_TRANSITION, 8'd1, LC_QNORMAL);
      issue(FUNC_TRANSITION, 8'd1, LC_DISPATCHED);
      issue(FUNC_TRANSITION, 8'd200, LC_QHIGH);
      issue(FUNC_RELEASE, 8'd16, LC_FREE);
      issue(FUNC_QUERY, 8'd15, LC_FREE);
      directed_total = requests_sent;

      drain();
      pauses++;

      while (requests_sent < directed_total + RANDOM_ITEMS) begin
         steady = (((requests_sent - directed_total) / 128) % 5) == 4;
         pick   = $urandom_range(0, 99);
         if (pick < 45) begin
            run_lifecycle(8'($urandom_range(0, POOL_SIZE - 1)));
         end else if (pick < 50) begin
            burst = $urandom_range(POOL_SIZE + 1, POOL_SIZE + 4);
            repeat (burst) issue(FUNC_RESERVE, any_index(), any_state());
         end else if (pick < 53) begin
            start = $urandom_range(0, POOL_SIZE - 1);
            for (int j = 0; j < POOL_SIZE; j++)
               issue(FUNC_RELEASE, 8'((start + j) % POOL_SIZE), any_state());
         end else begin
            random_request();
         end
         if ((requests_sent - directed_total) / 300 >= pauses) begin
            drain();
            pauses++;
         end
      end

      drain();
      repeat (4) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d requests (%0d directed), checked %0d responses, %0d mismatches.",
               requests_sent, directed_total, responses_seen, mismatch_count);
      $display("Reserves refused on an empty pool: %0d; slots walked to responded: %0d.",
               empty_denials, completed_lifecycles);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
